// File: sv/mqttrx_pkg.sv
// ----------------------------------------------------------------------------
// mqttrx_pkg - shared types and constants for the MQTT receive deframer
// Result kinds, ack codes, packet types and the front-to-back request format.
// ----------------------------------------------------------------------------
package mqttrx_pkg;

	localparam int MAX_TOPIC   = 255;
	localparam int MAX_PAYLOAD = 4095;
	localparam int MAX_PACKET  = 262144;

	localparam logic [2:0] KIND_TOPIC    = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
	localparam logic [2:0] KIND_MSG_END  = 3'd2;
	localparam logic [2:0] KIND_SEND_ACK = 3'd3;
	localparam logic [2:0] KIND_OUT_DONE = 3'd4;
	localparam logic [2:0] KIND_OUT_RECV = 3'd5;
	localparam logic [2:0] KIND_ERROR    = 3'd6;

	localparam logic [1:0] ACK_PUBACK  = 2'd0;
	localparam logic [1:0] ACK_PUBREC  = 2'd1;
	localparam logic [1:0] ACK_PUBREL  = 2'd2;
	localparam logic [1:0] ACK_PUBCOMP = 2'd3;

	localparam logic ERR_UNKNOWN  = 1'b0;
	localparam logic ERR_OVERSIZE = 1'b1;

	localparam logic [3:0] TYPE_CONNACK  = 4'h2;
	localparam logic [3:0] TYPE_PUBLISH  = 4'h3;
	localparam logic [3:0] TYPE_PUBACK   = 4'h4;
	localparam logic [3:0] TYPE_PUBREC   = 4'h5;
	localparam logic [3:0] TYPE_PUBREL   = 4'h6;
	localparam logic [3:0] TYPE_PUBCOMP  = 4'h7;
	localparam logic [3:0] TYPE_PINGRESP = 4'hD;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	// action codes carried from front to back
	localparam logic [2:0] ACT_TOPIC   = 3'd0;  // one topic byte
	localparam logic [2:0] ACT_PAYLOAD = 3'd1;  // one payload byte
	localparam logic [2:0] ACT_PUB_END = 3'd2;  // publish end: opt ack + msg end
	localparam logic [2:0] ACT_ACKD    = 3'd3;  // outbound done
	localparam logic [2:0] ACT_RECV    = 3'd4;  // outbound received + PUBREL
	localparam logic [2:0] ACT_REL     = 3'd5;  // send PUBCOMP
	localparam logic [2:0] ACT_ERROR   = 3'd6;  // error

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [2:0]  act;
		logic [7:0]  data;
		logic [15:0] pid;
		logic [1:0]  qos;
		logic        err;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [1:0]  ack_code;
		logic [15:0] packet_id;
		logic [1:0]  msg_qos;
		logic        error_code;
		logic        last;
	} res_t;

endpackage

// File: sv/mqttrx_front.sv
// ----------------------------------------------------------------------------
// mqttrx_front - header, length and body decode
// Parses one byte per cycle while in_fire is high and turns each byte into at most one request.
// ----------------------------------------------------------------------------
module mqttrx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               op,
	input  logic [7:0]         rx_byte,
	output logic               req_valid,
	output mqttrx_pkg::req_t   req
);

	logic [1:0]  phase_q;
	logic [7:0]  header_q;
	logic [27:0] rlen_q;
	logic [2:0]  lcnt_q;
	logic [27:0] bcnt_q;
	logic [15:0] tlen_q;
	logic [15:0] pid_q;
	logic [12:0] pemit_q;
	logic        pvalid_q;
	logic        err_q;

	logic [3:0]  ptype;
	logic [1:0]  qos;
	logic [27:0] rlen_n;
	logic [27:0] bcnt_n;
	logic [15:0] tlen_full;
	logic [15:0] pid_n;
	logic [16:0] tlen2, tlen4;
	logic        len_done, pkt_end, oversize;
	logic [28:0] total;

	assign ptype = header_q[7:4];
	assign qos   = header_q[2:1];
	assign tlen2 = {1'b0, tlen_q} + 17'd2;
	assign tlen4 = {1'b0, tlen_q} + 17'd4;
	assign tlen_full = {tlen_q[15:8], rx_byte};
	assign bcnt_n = bcnt_q + 28'd1;
	assign pid_n  = {pid_q[7:0], rx_byte};

	always_comb begin
		rlen_n = rlen_q;
		case (lcnt_q[1:0])
			2'd0: rlen_n[6:0]   = rx_byte[6:0];
			2'd1: rlen_n[13:7]  = rx_byte[6:0];
			2'd2: rlen_n[20:14] = rx_byte[6:0];
			default: rlen_n[27:21] = rx_byte[6:0];
		endcase
	end
	assign len_done = !rx_byte[7] || (lcnt_q == 3'd3);
	assign total    = 29'd2 + {26'd0, lcnt_q} + {1'b0, rlen_n};
	assign oversize = total > 29'(mqttrx_pkg::MAX_PACKET);
	assign pkt_end  = bcnt_n >= rlen_q;

	// end-of-packet request from the type; pid is the id as of packet end
	function automatic logic end_req(input logic [3:0] t, input logic pv,
		input logic [27:0] rl, output logic [2:0] a);
		logic hid;
		hid = rl >= 28'd2;
		a = mqttrx_pkg::ACT_ERROR;
		end_req = 1'b0;
		case (t)
			mqttrx_pkg::TYPE_PUBLISH: begin
				a = mqttrx_pkg::ACT_PUB_END; end_req = pv;
			end
			mqttrx_pkg::TYPE_PUBACK, mqttrx_pkg::TYPE_PUBCOMP: begin
				a = mqttrx_pkg::ACT_ACKD; end_req = hid;
			end
			mqttrx_pkg::TYPE_PUBREC: begin
				a = mqttrx_pkg::ACT_RECV; end_req = hid;
			end
			mqttrx_pkg::TYPE_PUBREL: begin
				a = mqttrx_pkg::ACT_REL; end_req = hid;
			end
			mqttrx_pkg::TYPE_CONNACK, mqttrx_pkg::TYPE_PINGRESP: end_req = 1'b0;
			default: begin
				a = mqttrx_pkg::ACT_ERROR; end_req = 1'b1;
			end
		endcase
	endfunction

	logic        rv;
	mqttrx_pkg::req_t rq;
	logic [1:0]  phase_n;
	logic [15:0] tlen_n, pidreg_n;
	logic        pvalid_n, err_n;
	logic [12:0] pemit_n;
	logic [2:0]  ea;
	logic        er;
	logic        is_pub;
	logic        pv_b;

	always_comb begin
		rv = 1'b0;
		rq = '0;
		phase_n = phase_q;
		tlen_n = tlen_q;
		pidreg_n = pid_q;
		pvalid_n = pvalid_q;
		err_n = err_q;
		pemit_n = pemit_q;
		ea = mqttrx_pkg::ACT_ERROR;
		er = 1'b0;
		is_pub = ptype == mqttrx_pkg::TYPE_PUBLISH;
		pv_b = pvalid_q;
		case (phase_q)
			mqttrx_pkg::PH_LENGTH: begin
				if (len_done) begin
					if (oversize) begin
						rv = 1'b1;
						rq.act = mqttrx_pkg::ACT_ERROR;
						rq.err = mqttrx_pkg::ERR_OVERSIZE;
						err_n = 1'b1;
						phase_n = mqttrx_pkg::PH_HEADER;
					end else if (rlen_n == 28'd0) begin
						er = end_req(ptype, pvalid_q, rlen_n, ea);
						rv = er;
						rq.act = ea;
						rq.pid = pid_q;
						rq.qos = qos;
						if (er && ea == mqttrx_pkg::ACT_ERROR) err_n = 1'b1;
						phase_n = mqttrx_pkg::PH_HEADER;
					end else begin
						phase_n = mqttrx_pkg::PH_BODY;
					end
				end
			end
			mqttrx_pkg::PH_BODY: begin
				if (is_pub) begin
					if (bcnt_q == 28'd0) begin
						tlen_n = {rx_byte, 8'd0};
					end else if (bcnt_q == 28'd1) begin
						tlen_n = tlen_full;
						pv_b = (tlen_full <= 16'(mqttrx_pkg::MAX_TOPIC)) &&
							({12'd0, tlen_full} + 28'd2 <= rlen_q) &&
							(qos == 2'd0 || {12'd0, tlen_full} + 28'd4 <= rlen_q);
						pvalid_n = pv_b;
					end else if (bcnt_q < {11'd0, tlen2}) begin
						rv = pvalid_q;
						rq.act = mqttrx_pkg::ACT_TOPIC;
						rq.data = rx_byte;
					end else if (qos != 2'd0 && bcnt_q < {11'd0, tlen4}) begin
						pidreg_n = pid_n;
					end else if (pvalid_q && pemit_q < 13'(mqttrx_pkg::MAX_PAYLOAD)) begin
						rv = 1'b1;
						rq.act = mqttrx_pkg::ACT_PAYLOAD;
						rq.data = rx_byte;
						pemit_n = pemit_q + 13'd1;
					end
				end else if (bcnt_q < 28'd2) begin
					pidreg_n = pid_n;
				end
				if (pkt_end) begin
					// the last body byte of a publish may also carry a data
					// request; it is then merged with the publish end
					er = end_req(ptype, pv_b, rlen_q, ea);
					phase_n = mqttrx_pkg::PH_HEADER;
					if (er) begin
						if (rv) begin
							// data byte and end in same step: merge flag
							rq.act = (rq.act == mqttrx_pkg::ACT_TOPIC) ?
								mqttrx_pkg::ACT_TOPIC : mqttrx_pkg::ACT_PAYLOAD;
						end
						rq.pid = pidreg_n;
						rq.qos = qos;
						if (!rv) rq.act = ea;
						if (ea == mqttrx_pkg::ACT_ERROR) err_n = 1'b1;
						rv = 1'b1;
					end
				end
			end
			default: begin
				// header byte: start a fresh packet
				phase_n = mqttrx_pkg::PH_LENGTH;
				tlen_n = '0;
				pidreg_n = '0;
				pvalid_n = 1'b0;
				pemit_n = '0;
			end
		endcase
	end

	// A data byte on the last body byte is followed by publish end in the same
	// step; the request then carries the byte plus an end flag in err.
	logic both;
	assign both = (phase_q == mqttrx_pkg::PH_BODY) && pkt_end && er &&
		(rq.act == mqttrx_pkg::ACT_TOPIC || rq.act == mqttrx_pkg::ACT_PAYLOAD) &&
		is_pub;

	always_comb begin
		req_valid = in_fire && !op && !err_q && rv;
		req = rq;
		req.err = both ? 1'b1 : rq.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mqttrx_pkg::PH_HEADER;
			err_q <= 1'b0;
			header_q <= '0; rlen_q <= '0; lcnt_q <= '0; bcnt_q <= '0;
			tlen_q <= '0; pid_q <= '0; pemit_q <= '0; pvalid_q <= 1'b0;
		end else if (in_fire) begin
			if (op) begin
				phase_q <= mqttrx_pkg::PH_HEADER;
				err_q <= 1'b0;
			end else if (!err_q) begin
				phase_q <= phase_n;
				err_q <= err_n;
				tlen_q <= tlen_n;
				pid_q <= pidreg_n;
				pvalid_q <= pvalid_n;
				pemit_q <= pemit_n;
				case (phase_q)
					mqttrx_pkg::PH_HEADER: begin
						header_q <= rx_byte;
						rlen_q <= '0; lcnt_q <= '0; bcnt_q <= '0;
					end
					mqttrx_pkg::PH_LENGTH: begin
						rlen_q <= rlen_n;
						lcnt_q <= lcnt_q + 3'd1;
					end
					default: bcnt_q <= bcnt_n;
				endcase
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && op |=> phase_q == mqttrx_pkg::PH_HEADER && !err_q)
		else $error("restart did not clear parser");
	assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(in_fire && op) |=> err_q)
		else $error("error flag not sticky");
	assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> !req_valid)
		else $error("request while in error");
	assert property (@(posedge clk) disable iff (!arst_n)
		pemit_q <= 13'(mqttrx_pkg::MAX_PAYLOAD))
		else $error("payload limit overrun");

endmodule

// File: sv/mqttrx_queue.sv
// ----------------------------------------------------------------------------
// mqttrx_queue - request queue between decode and result sequencer
// Small flop FIFO; full/empty from a count.
// ----------------------------------------------------------------------------
module mqttrx_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  mqttrx_pkg::req_t wr_data,
	output logic             full,
	output logic             almost_full,
	input  logic             rd_en,
	output logic             empty,
	output mqttrx_pkg::req_t rd_data
);

	mqttrx_pkg::req_t mem_q [mqttrx_pkg::QDEPTH];
	logic [mqttrx_pkg::QAW-1:0] wp_q, rp_q;
	logic [mqttrx_pkg::QAW:0]   cnt_q;

	assign full  = cnt_q == (mqttrx_pkg::QAW+1)'(mqttrx_pkg::QDEPTH);
	assign almost_full = cnt_q >= (mqttrx_pkg::QAW+1)'(mqttrx_pkg::QDEPTH - 1);
	assign empty = cnt_q == '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (mqttrx_pkg::QAW+1)'(wr_en) - (mqttrx_pkg::QAW+1)'(rd_en);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(wr_en && full && !rd_en))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && empty))
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (mqttrx_pkg::QAW+1)'(mqttrx_pkg::QDEPTH))
		else $error("queue count out of range");

endmodule

// File: sv/mqttrx_back.sv
// ----------------------------------------------------------------------------
// mqttrx_back - result sequencer
// Expands one request into one to three result items, one per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module mqttrx_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  mqttrx_pkg::req_t q_data,
	output logic             q_rd,
	output logic             out_valid,
	input  logic             out_ready,
	output mqttrx_pkg::res_t res
);

	logic [1:0] idx_q;       // result index within current request
	logic [1:0] nres;
	mqttrx_pkg::res_t r;
	logic is_last;
	logic data_end;          // data byte followed by publish end
	logic has_ack;

	assign data_end = q_data.err &&
		(q_data.act == mqttrx_pkg::ACT_TOPIC || q_data.act == mqttrx_pkg::ACT_PAYLOAD);
	assign has_ack = q_data.qos == 2'd1 || q_data.qos == 2'd2;

	always_comb begin
		r = '0;
		nres = 2'd1;
		case (q_data.act)
			mqttrx_pkg::ACT_TOPIC, mqttrx_pkg::ACT_PAYLOAD: begin
				nres = data_end ? (has_ack ? 2'd3 : 2'd2) : 2'd1;
				if (idx_q == 2'd0) begin
					r.kind = (q_data.act == mqttrx_pkg::ACT_TOPIC) ?
						mqttrx_pkg::KIND_TOPIC : mqttrx_pkg::KIND_PAYLOAD;
					r.data_byte = q_data.data;
				end else if (idx_q == 2'd1 && has_ack) begin
					r.kind = mqttrx_pkg::KIND_SEND_ACK;
					r.ack_code = (q_data.qos == 2'd1) ? mqttrx_pkg::ACK_PUBACK :
						mqttrx_pkg::ACK_PUBREC;
					r.packet_id = q_data.pid;
				end else begin
					r.kind = mqttrx_pkg::KIND_MSG_END;
					r.packet_id = (q_data.qos != 2'd0) ? q_data.pid : 16'd0;
					r.msg_qos = q_data.qos;
				end
			end
			mqttrx_pkg::ACT_PUB_END: begin
				nres = has_ack ? 2'd2 : 2'd1;
				if (idx_q == 2'd0 && has_ack) begin
					r.kind = mqttrx_pkg::KIND_SEND_ACK;
					r.ack_code = (q_data.qos == 2'd1) ? mqttrx_pkg::ACK_PUBACK :
						mqttrx_pkg::ACK_PUBREC;
					r.packet_id = q_data.pid;
				end else begin
					r.kind = mqttrx_pkg::KIND_MSG_END;
					r.packet_id = (q_data.qos != 2'd0) ? q_data.pid : 16'd0;
					r.msg_qos = q_data.qos;
				end
			end
			mqttrx_pkg::ACT_ACKD: begin
				r.kind = mqttrx_pkg::KIND_OUT_DONE;
				r.packet_id = q_data.pid;
			end
			mqttrx_pkg::ACT_RECV: begin
				nres = 2'd2;
				r.packet_id = q_data.pid;
				if (idx_q == 2'd0) begin
					r.kind = mqttrx_pkg::KIND_OUT_RECV;
				end else begin
					r.kind = mqttrx_pkg::KIND_SEND_ACK;
					r.ack_code = mqttrx_pkg::ACK_PUBREL;
				end
			end
			mqttrx_pkg::ACT_REL: begin
				r.kind = mqttrx_pkg::KIND_SEND_ACK;
				r.ack_code = mqttrx_pkg::ACK_PUBCOMP;
				r.packet_id = q_data.pid;
			end
			default: begin
				r.kind = mqttrx_pkg::KIND_ERROR;
				r.error_code = q_data.err;
			end
		endcase
		is_last = idx_q == nres - 2'd1;
		r.last = is_last;
	end

	// output register: loads when empty or being drained
	logic load;
	assign load = !q_empty && (!out_valid || out_ready);
	assign q_rd = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) res <= r;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res))
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n) idx_q != 2'd3)
		else $error("result index out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> !q_empty)
		else $error("request left mid-expansion");

endmodule

// File: sv/mqtt_rx_packet_parser.sv
// ----------------------------------------------------------------------------
// mqtt_rx_packet_parser - MQTT 3.1.1 receive deframer
// Decodes received bytes into topic/payload bytes, ack requests and events.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  --------+-------------------+----------------------------------------------
//  in      | in_valid/in_ready | op, rx_byte
//  out     | out_valid/out_rdy | kind, data_byte, ack_code, packet_id,
//          |  (out_ready)      |  msg_qos, error_code, last
//
// One byte is taken per cycle while the request queue is not almost full;
// decode in the front is combinational. Each byte yields at most one queued
// request, and the back expands a request into one to three results, one per
// cycle while out_ready allows. in_ready drops only when the queue nears full
// (output stalled or multi-result expansion).
// Reset clears parser state, the queue pointers and the output valid.
// ----------------------------------------------------------------------------
module mqtt_rx_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic [1:0]  ack_code,
	output logic [15:0] packet_id,
	output logic [1:0]  msg_qos,
	output logic        error_code,
	output logic        last
);

	logic             in_fire;
	logic             req_valid;
	mqttrx_pkg::req_t req;
	logic             q_full, q_afull, q_empty, q_rd;
	mqttrx_pkg::req_t q_data;
	mqttrx_pkg::res_t res;

	// conservative: keep one slot free so a registered ready is not needed
	assign in_ready = !q_afull;
	assign in_fire  = in_valid && in_ready;

	mqttrx_front u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .op(op),
		.rx_byte(rx_byte), .req_valid(req_valid), .req(req)
	);

	mqttrx_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(req_valid), .wr_data(req),
		.full(q_full), .almost_full(q_afull), .rd_en(q_rd),
		.empty(q_empty), .rd_data(q_data)
	);

	mqttrx_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_data),
		.q_rd(q_rd), .out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign kind       = res.kind;
	assign data_byte  = res.data_byte;
	assign ack_code   = res.ack_code;
	assign packet_id  = res.packet_id;
	assign msg_qos    = res.msg_qos;
	assign error_code = res.error_code;
	assign last       = res.last;

	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !in_ready)
		else $error("input taken with full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind != 3'd7)
		else $error("bad result kind");

endmodule
